@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the top level of the CAN frame text logger.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/cftl_pkg.sv @@
// Types, constants and the microcode table of the CAN frame text logger.
`timescale 1ns / 1ps

package cftl_pkg;

  localparam int LINE_CHARS = 49;
  localparam int READY_W    = 5;

  // Field widths of the stream payloads.
  localparam int ID_W     = 12;
  localparam int LEN_W    = 4;
  localparam int DATA_W   = 64;
  localparam int STAMP_W  = 32;
  localparam int SEL_W    = 3;
  localparam int CHAR_W   = 8;
  localparam int BUF_W    = 3;
  localparam int POS_W    = 9;
  localparam int RLEN_W   = 10;
  localparam int STATUS_W = 2;

  localparam int S_TDATA_W = 120;
  localparam int M_TDATA_W = 40;

  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
  localparam logic [CHAR_W-1:0] CH_COLON   = 8'h3A;
  localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_NUL     = 8'h00;

  typedef enum logic [STATUS_W-1:0] {
    ST_CHAR     = 2'd0,
    ST_DROP     = 2'd1,
    ST_RELEASED = 2'd2,
    ST_BAD_BUF  = 2'd3
  } status_e;

  // What the datapath does during one microcode step.
  typedef enum logic [2:0] {
    ACT_FETCH,
    ACT_DISPATCH,
    ACT_SCAN,
    ACT_DROP,
    ACT_START,
    ACT_CHAR,
    ACT_REL_APPLY,
    ACT_REL_EMIT
  } act_e;

  // Where a character step takes its character from.
  typedef enum logic [2:0] {
    SRC_LIT,
    SRC_LINE,
    SRC_ID,
    SRC_LEN,
    SRC_DATA_HI,
    SRC_DATA_LO,
    SRC_STAMP
  } src_e;

  localparam int PC_W        = 6;
  localparam int UCODE_DEPTH = 56;

  typedef struct packed {
    act_e            act;
    src_e            src;
    logic [7:0]      arg;   // nibble index, data slot or literal character
    logic            jump;  // take tgt when the step completes
    logic [PC_W-1:0] tgt;
  } ctrl_t;

  typedef struct packed {
    logic in_fire;
    logic op_rel;
    logic cur_free;
    logic scan_last;
    logic push_ok;
  } cond_t;

  localparam logic [PC_W-1:0] PC_FETCH     = 6'd0;
  localparam logic [PC_W-1:0] PC_START     = 6'd4;
  localparam logic [PC_W-1:0] PC_REL_APPLY = 6'd54;

  // Step 0 waits for an item, steps 5 to 53 emit the 49 characters of a line.
  localparam ctrl_t UCODE [UCODE_DEPTH] = '{
    '{ACT_FETCH,     SRC_LIT,     8'd0,       1'b0, PC_FETCH},
    '{ACT_DISPATCH,  SRC_LIT,     8'd0,       1'b0, PC_REL_APPLY},
    '{ACT_SCAN,      SRC_LIT,     8'd0,       1'b0, PC_START},
    '{ACT_DROP,      SRC_LIT,     8'd0,       1'b1, PC_FETCH},
    '{ACT_START,     SRC_LIT,     8'd0,       1'b0, PC_FETCH},
    '{ACT_CHAR,      SRC_LINE,    8'd7,       1'b0, PC_FETCH},
    '{ACT_CHAR,      SRC_LINE,    8'd6,       1'b0, PC_FETCH},
    '{ACT_CHAR,      SRC_LINE,    8'd5,       1'b0, PC_FETCH},
    '{ACT_CHAR,      SRC_LINE,    8'd4,       1'b0, PC_FETCH},
    '{ACT_CHAR,      SRC_LINE,    8'd3,       1'b0, PC_FETCH},
    '{ACT_CHAR,      SRC_LINE,    8'd2,       1'b0, PC_FETCH},
    '{ACT_CHAR,      SRC_LINE,    8'd1,       1'b0, PC_FETCH},
    '{ACT_CHAR,      SRC_LINE,    8'd0,       1'b0, PC_FETCH},
    '{ACT_CHAR,      SRC_LIT,     CH_SPACE,   1'b0, PC_FETCH},
    '{ACT_CHAR,      SRC_ID,      8'd2,       1'b0, PC_FETCH},
    '{ACT_CHAR,      SRC_ID,      8'd1,       1'b0, PC_FETCH},
    '{ACT_CHAR,      SRC_ID,      8'd0,       1'b0, PC_FETCH},
    '{ACT_CHAR,      SRC_LIT,     CH_SPACE,   1'b0, PC_FETCH},
    '{ACT_CHAR,      SRC_LEN,     8'd0,       1'b0, PC_FETCH},
    '{ACT_CHAR,      SRC_LIT,     CH_COLON,   1'b0, PC_FETCH},
    '{ACT_CHAR,      SRC_LIT,     CH_SPACE,   1'b0, PC_FETCH},
    '{ACT_CHAR,      SRC_DATA_HI, 8'd0,       1'b0, PC_FETCH},
    '{ACT_CHAR,      SRC_DATA_LO, 8'd0,       1'b0, PC_FETCH},
    '{ACT_CHAR,      SRC_LIT,     CH_SPACE,   1'b0, PC_FETCH},
    '{ACT_CHAR,      SRC_DATA_HI, 8'd1,       1'b0, PC_FETCH},
    '{ACT_CHAR,      SRC_DATA_LO, 8'd1,       1'b0, PC_FETCH},
    '{ACT_CHAR,      SRC_LIT,     CH_SPACE,   1'b0, PC_FETCH},
    '{ACT_CHAR,      SRC_DATA_HI, 8'd2,       1'b0, PC_FETCH},
    '{ACT_CHAR,      SRC_DATA_LO, 8'd2,       1'b0, PC_FETCH},
    '{ACT_CHAR,      SRC_LIT,     CH_SPACE,   1'b0, PC_FETCH},
    '{ACT_CHAR,      SRC_DATA_HI, 8'd3,       1'b0, PC_FETCH},
    '{ACT_CHAR,      SRC_DATA_LO, 8'd3,       1'b0, PC_FETCH},
    '{ACT_CHAR,      SRC_LIT,     CH_SPACE,   1'b0, PC_FETCH},
    '{ACT_CHAR,      SRC_DATA_HI, 8'd4,       1'b0, PC_FETCH},
    '{ACT_CHAR,      SRC_DATA_LO, 8'd4,       1'b0, PC_FETCH},
    '{ACT_CHAR,      SRC_LIT,     CH_SPACE,   1'b0, PC_FETCH},
    '{ACT_CHAR,      SRC_DATA_HI, 8'd5,       1'b0, PC_FETCH},
    '{ACT_CHAR,      SRC_DATA_LO, 8'd5,       1'b0, PC_FETCH},
    '{ACT_CHAR,      SRC_LIT,     CH_SPACE,   1'b0, PC_FETCH},
    '{ACT_CHAR,      SRC_DATA_HI, 8'd6,       1'b0, PC_FETCH},
    '{ACT_CHAR,      SRC_DATA_LO, 8'd6,       1'b0, PC_FETCH},
    '{ACT_CHAR,      SRC_LIT,     CH_SPACE,   1'b0, PC_FETCH},
    '{ACT_CHAR,      SRC_DATA_HI, 8'd7,       1'b0, PC_FETCH},
    '{ACT_CHAR,      SRC_DATA_LO, 8'd7,       1'b0, PC_FETCH},
    '{ACT_CHAR,      SRC_LIT,     CH_SPACE,   1'b0, PC_FETCH},
    '{ACT_CHAR,      SRC_STAMP,   8'd7,       1'b0, PC_FETCH},
    '{ACT_CHAR,      SRC_STAMP,   8'd6,       1'b0, PC_FETCH},
    '{ACT_CHAR,      SRC_STAMP,   8'd5,       1'b0, PC_FETCH},
    '{ACT_CHAR,      SRC_STAMP,   8'd4,       1'b0, PC_FETCH},
    '{ACT_CHAR,      SRC_STAMP,   8'd3,       1'b0, PC_FETCH},
    '{ACT_CHAR,      SRC_STAMP,   8'd2,       1'b0, PC_FETCH},
    '{ACT_CHAR,      SRC_STAMP,   8'd1,       1'b0, PC_FETCH},
    '{ACT_CHAR,      SRC_STAMP,   8'd0,       1'b0, PC_FETCH},
    '{ACT_CHAR,      SRC_LIT,     CH_NEWLINE, 1'b1, PC_FETCH},
    '{ACT_REL_APPLY, SRC_LIT,     8'd0,       1'b0, PC_FETCH},
    '{ACT_REL_EMIT,  SRC_LIT,     8'd0,       1'b1, PC_FETCH}
  };

  // Uppercase ASCII hex digit.
  function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] nib);
    logic [CHAR_W-1:0] wide;
    wide = {4'h0, nib};
    if (nib < 4'd10) begin
      hex_char = 8'h30 + wide;
    end else begin
      hex_char = 8'h37 + wide;
    end
  endfunction

endpackage

@@ hw/rtl/can_frame_text_logger.sv @@
// Top level of the CAN frame text logger: microcode sequencer plus datapath.
// A logged frame passes through fetch, dispatch, one or more scan steps (up to NUM_BUFFERS)
// and start; its 49 characters then leave one per cycle unless stalled.
// A dropped frame ends in a drop step, a release item in release apply and release emit.
// A result is valid in the cycle after the step that pushes it.
// Reset clears the line number, the current buffer, all fill levels and ready flags.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module can_frame_text_logger #(
  parameter int NUM_BUFFERS  = 5,
  parameter int BUFFER_BYTES = 512
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid_i,
  output logic          s_axis_tready_o,
  // frame_id[11:0], frame_len[15:12], frame_data[79:16], stamp_us[111:80],
  // release_sel[114:112], zero fill above
  input  logic [119:0]  s_axis_tdata_i,
  // op[0]
  input  logic [0:0]    s_axis_tuser_i,
  output logic          m_axis_tvalid_o,
  input  logic          m_axis_tready_i,
  // ascii_char[7:0], buf_num[10:8], byte_pos[19:11], released_len[29:20],
  // ready_flags[34:30], zero fill above
  output logic [39:0]   m_axis_tdata_o,
  // status[1:0]
  output logic [1:0]    m_axis_tuser_o,
  output logic          m_axis_tlast_o
);

  cftl_pkg::ctrl_t ctrl;
  cftl_pkg::cond_t cond;

  cftl_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cond_i (cond),
    .ctrl_o (ctrl)
  );

  cftl_dp #(
    .NUM_BUFFERS  (NUM_BUFFERS),
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctrl_i          (ctrl),
    .cond_o          (cond),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  // Every accepted item is followed by the dispatch step.
  `ASSERT_NEXT(a_fire_dispatch, s_axis_tvalid_i && s_axis_tready_o, ctrl.act == cftl_pkg::ACT_DISPATCH, "accepted item not dispatched")

  // Drop, release and bad-buffer results are single transfers and end the item.
  `ASSERT_IMPL(a_single_last, m_axis_tvalid_o && (m_axis_tuser_o != cftl_pkg::ST_CHAR), m_axis_tlast_o, "single result without tlast")

  // After the newline is pushed the sequencer returns to waiting for an item.
  `ASSERT_NEXT(a_line_end, (ctrl.act == cftl_pkg::ACT_CHAR) && ctrl.jump && cond.push_ok, ctrl.act == cftl_pkg::ACT_FETCH, "sequencer did not return after line")

endmodule

@@ hw/rtl/cftl_seq.sv @@
// Microcode sequencer: step counter, control word lookup and branching.
`timescale 1ns / 1ps

module cftl_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cftl_pkg::cond_t     cond_i,
  output cftl_pkg::ctrl_t     ctrl_o
);

  logic [cftl_pkg::PC_W-1:0] pc_q;
  logic [cftl_pkg::PC_W-1:0] pc_d;
  logic [cftl_pkg::PC_W-1:0] pc_inc;
  cftl_pkg::ctrl_t           word;

  assign word   = cftl_pkg::UCODE[pc_q];
  assign ctrl_o = word;
  assign pc_inc = pc_q + cftl_pkg::PC_W'(1);

  always_comb begin
    pc_d = pc_q;
    unique case (word.act)
      cftl_pkg::ACT_FETCH: begin
        if (cond_i.in_fire) begin
          pc_d = pc_inc;
        end
      end
      cftl_pkg::ACT_DISPATCH: begin
        pc_d = cond_i.op_rel ? word.tgt : pc_inc;
      end
      cftl_pkg::ACT_SCAN: begin
        // Stay on the scan step while full buffers are skipped.
        if (cond_i.cur_free) begin
          pc_d = word.tgt;
        end else if (cond_i.scan_last) begin
          pc_d = pc_inc;
        end
      end
      cftl_pkg::ACT_DROP, cftl_pkg::ACT_CHAR, cftl_pkg::ACT_REL_EMIT: begin
        if (cond_i.push_ok) begin
          pc_d = word.jump ? word.tgt : pc_inc;
        end
      end
      cftl_pkg::ACT_START, cftl_pkg::ACT_REL_APPLY: begin
        pc_d = pc_inc;
      end
      default: begin
        pc_d = cftl_pkg::PC_FETCH;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= cftl_pkg::PC_FETCH;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

@@ hw/rtl/cftl_dp.sv @@
// Datapath: buffer bookkeeping, character formatting and the output register.
`timescale 1ns / 1ps

module cftl_dp #(
  parameter int NUM_BUFFERS  = 5,
  parameter int BUFFER_BYTES = 512
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  cftl_pkg::ctrl_t                      ctrl_i,
  output cftl_pkg::cond_t                      cond_o,
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  input  logic [cftl_pkg::S_TDATA_W-1:0]       s_axis_tdata_i,
  input  logic [0:0]                           s_axis_tuser_i,
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  output logic [cftl_pkg::M_TDATA_W-1:0]       m_axis_tdata_o,
  output logic [cftl_pkg::STATUS_W-1:0]        m_axis_tuser_o,
  output logic                                 m_axis_tlast_o
);

  localparam int IDX_W  = $clog2(NUM_BUFFERS);
  localparam int FILL_W = $clog2(BUFFER_BYTES);
  localparam logic [FILL_W-1:0] FULL_AT  = FILL_W'(BUFFER_BYTES - cftl_pkg::LINE_CHARS);
  localparam logic [FILL_W-1:0] LINE_ADD = FILL_W'(cftl_pkg::LINE_CHARS);
  localparam logic [IDX_W-1:0]  LAST_BUF = IDX_W'(NUM_BUFFERS - 1);

  // Control state.
  logic [31:0]            line_q;
  logic [IDX_W-1:0]       cur_q;
  logic [FILL_W-1:0]      fill_q [NUM_BUFFERS];
  logic [NUM_BUFFERS-1:0] ready_q;
  logic [IDX_W-1:0]       scan_q;
  logic                   out_valid_q;

  // Latched item and line payload.
  logic                             op_q;
  logic [cftl_pkg::ID_W-1:0]        id_q;
  logic [cftl_pkg::LEN_W-1:0]       len_q;
  logic [cftl_pkg::DATA_W-1:0]      data_q;
  logic [cftl_pkg::STAMP_W-1:0]     stamp_q;
  logic [cftl_pkg::SEL_W-1:0]       sel_q;
  logic [FILL_W-1:0]                pos_q;
  logic [IDX_W-1:0]                 wbuf_q;
  logic [FILL_W-1:0]                rlen_q;
  logic [cftl_pkg::M_TDATA_W-1:0]   out_data_q;
  logic [cftl_pkg::STATUS_W-1:0]    out_user_q;
  logic                             out_last_q;

  logic                          in_fire;
  logic                          push_ok;
  logic                          push;
  logic [IDX_W-1:0]              rd_idx;
  logic [FILL_W-1:0]             fill_rd;
  logic [FILL_W-1:0]             fill_sum;
  logic                          cur_free;
  logic                          sel_ok;
  logic [IDX_W-1:0]              cur_next;
  logic [cftl_pkg::READY_W-1:0]  flags;
  logic [cftl_pkg::CHAR_W-1:0]   char_val;
  logic [cftl_pkg::CHAR_W-1:0]   o_char;
  logic [cftl_pkg::BUF_W-1:0]    o_buf;
  logic [cftl_pkg::POS_W-1:0]    o_pos;
  logic [cftl_pkg::RLEN_W-1:0]   o_rlen;
  cftl_pkg::status_e             o_status;
  logic                          o_last;

  assign s_axis_tready_o = (ctrl_i.act == cftl_pkg::ACT_FETCH);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign push_ok         = !out_valid_q || m_axis_tready_i;
  assign push            = push_ok && ((ctrl_i.act == cftl_pkg::ACT_DROP) ||
                                       (ctrl_i.act == cftl_pkg::ACT_CHAR) ||
                                       (ctrl_i.act == cftl_pkg::ACT_REL_EMIT));

  // The fill levels have one read port, steered to the release target when needed.
  assign sel_ok   = (32'(sel_q) < NUM_BUFFERS);
  assign rd_idx   = (ctrl_i.act == cftl_pkg::ACT_REL_APPLY) ? sel_q[IDX_W-1:0] : cur_q;
  assign fill_rd  = fill_q[rd_idx];
  assign fill_sum = fill_rd + LINE_ADD;
  assign cur_free = (fill_rd < FULL_AT);
  assign cur_next = (cur_q == LAST_BUF) ? '0 : cur_q + IDX_W'(1);

  assign cond_o.in_fire   = in_fire;
  assign cond_o.op_rel    = op_q;
  assign cond_o.cur_free  = cur_free;
  assign cond_o.scan_last = (scan_q == LAST_BUF);
  assign cond_o.push_ok   = push_ok;

  for (genvar gi = 0; gi < cftl_pkg::READY_W; gi++) begin : g_flags
    if (gi < NUM_BUFFERS) begin : g_on
      assign flags[gi] = ready_q[gi];
    end else begin : g_off
      assign flags[gi] = 1'b0;
    end
  end

  // Character of the current line step.
  always_comb begin
    logic [3:0]                  nib;
    logic [cftl_pkg::LEN_W-1:0]  dlen;
    logic [cftl_pkg::LEN_W-1:0]  slot_sum;
    logic [7:0]                  byte_val;
    logic                        use_hex;
    nib      = 4'h0;
    use_hex  = 1'b1;
    char_val = cftl_pkg::CH_SPACE;
    dlen     = (len_q > 4'd8) ? 4'd8 : len_q;
    slot_sum = dlen + {1'b0, ctrl_i.arg[2:0]};
    byte_val = data_q[{slot_sum[2:0], 3'b000} +: 8];
    case (ctrl_i.src)
      cftl_pkg::SRC_LIT: begin
        use_hex  = 1'b0;
        char_val = ctrl_i.arg;
      end
      cftl_pkg::SRC_LINE:  nib = line_q[{ctrl_i.arg[2:0], 2'b00} +: 4];
      cftl_pkg::SRC_ID:    nib = id_q[{ctrl_i.arg[1:0], 2'b00} +: 4];
      cftl_pkg::SRC_LEN:   nib = len_q;
      cftl_pkg::SRC_STAMP: nib = stamp_q[{ctrl_i.arg[2:0], 2'b00} +: 4];
      cftl_pkg::SRC_DATA_HI, cftl_pkg::SRC_DATA_LO: begin
        // Data is right-aligned: slot i shows byte (dlen + i - 8) if that exists.
        use_hex = slot_sum[3];
        nib     = (ctrl_i.src == cftl_pkg::SRC_DATA_HI) ? byte_val[7:4] : byte_val[3:0];
      end
      default: use_hex = 1'b0;
    endcase
    if (use_hex) begin
      char_val = cftl_pkg::hex_char(nib);
    end
  end

  // Fields of the result pushed in this step.
  always_comb begin
    o_char   = cftl_pkg::CH_NUL;
    o_buf    = cftl_pkg::BUF_W'(cur_q);
    o_pos    = '0;
    o_rlen   = '0;
    o_status = cftl_pkg::ST_DROP;
    o_last   = 1'b1;
    unique case (ctrl_i.act)
      cftl_pkg::ACT_CHAR: begin
        o_char   = char_val;
        o_buf    = cftl_pkg::BUF_W'(wbuf_q);
        o_pos    = cftl_pkg::POS_W'(pos_q);
        o_status = cftl_pkg::ST_CHAR;
        o_last   = ctrl_i.jump;
      end
      cftl_pkg::ACT_REL_EMIT: begin
        o_buf    = sel_q;
        o_rlen   = cftl_pkg::RLEN_W'(rlen_q);
        o_status = sel_ok ? cftl_pkg::ST_RELEASED : cftl_pkg::ST_BAD_BUF;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_q      <= '0;
      cur_q       <= '0;
      ready_q     <= '0;
      scan_q      <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NUM_BUFFERS; i++) begin
        fill_q[i] <= '0;
      end
    end else begin
      if (push) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (ctrl_i.act)
        cftl_pkg::ACT_FETCH: begin
          if (in_fire) begin
            scan_q <= '0;
          end
        end
        cftl_pkg::ACT_SCAN: begin
          if (!cur_free) begin
            ready_q[cur_q] <= 1'b1;
            cur_q          <= cur_next;
            scan_q         <= scan_q + IDX_W'(1);
          end
        end
        cftl_pkg::ACT_START: begin
          fill_q[cur_q] <= fill_sum;
          if (fill_sum >= FULL_AT) begin
            ready_q[cur_q] <= 1'b1;
            cur_q          <= cur_next;
          end
        end
        cftl_pkg::ACT_CHAR: begin
          if (push_ok && ctrl_i.jump) begin
            line_q <= line_q + 32'd1;
          end
        end
        cftl_pkg::ACT_REL_APPLY: begin
          if (sel_ok) begin
            fill_q[rd_idx]  <= '0;
            ready_q[rd_idx] <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q    <= s_axis_tuser_i[0];
      id_q    <= s_axis_tdata_i[11:0];
      len_q   <= s_axis_tdata_i[15:12];
      data_q  <= s_axis_tdata_i[79:16];
      stamp_q <= s_axis_tdata_i[111:80];
      sel_q   <= s_axis_tdata_i[114:112];
    end
    if (ctrl_i.act == cftl_pkg::ACT_START) begin
      pos_q  <= fill_rd;
      wbuf_q <= cur_q;
    end else if ((ctrl_i.act == cftl_pkg::ACT_CHAR) && push_ok) begin
      pos_q <= pos_q + FILL_W'(1);
    end
    if (ctrl_i.act == cftl_pkg::ACT_REL_APPLY) begin
      rlen_q <= sel_ok ? fill_rd : '0;
    end
    if (push) begin
      out_data_q <= {5'b0, flags, o_rlen, o_pos, o_buf, o_char};
      out_user_q <= o_status;
      out_last_q <= o_last;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule

@@ test/tb_cftl_pkg.sv @@
// Operation codes and buffer geometry shared by the CAN frame text logger testbench files.
`timescale 1ns / 1ps

package tb_cftl_pkg;

  localparam int TB_NUM_BUFS  = 5;
  localparam int TB_BUF_BYTES = 512;

  typedef enum logic {
    OP_LOG     = 1'b0,
    OP_RELEASE = 1'b1
  } log_op_e;

endpackage

@@ test/cftl_checker.sv @@
// Checker for the CAN frame text logger: predicts every buffer write and compares it.
`timescale 1ns / 1ps

module cftl_checker
  import cftl_pkg::*;
  import tb_cftl_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  input  logic         in_ready_i,
  input  logic [119:0] in_data_i,
  input  logic [0:0]   in_user_i,
  input  logic         out_valid_i,
  input  logic         out_ready_i,
  input  logic [39:0]  out_data_i,
  input  logic [1:0]   out_user_i,
  input  logic         out_last_i,
  output int           fail_count_o,
  output int           pending_o,
  output int           checked_o,
  output int           drops_o
);

  typedef struct packed {
    logic [CHAR_W-1:0]  ch;
    logic [BUF_W-1:0]   bnum;
    logic [POS_W-1:0]   pos;
    status_e            st;
    logic [RLEN_W-1:0]  rlen;
    logic [READY_W-1:0] rdy;
    logic               last;
  } buf_write_t;

  buf_write_t expected_writes [$];
  buf_write_t got_write;
  buf_write_t want_write;

  // Shadow copy of the logger state.
  logic [31:0]       line_no;
  logic [BUF_W-1:0]  cur_buf;
  logic [RLEN_W-1:0] fill [TB_NUM_BUFS];
  logic              rdy_bit [TB_NUM_BUFS];

  int errors;
  int checked;
  int drops;

  function automatic logic [CHAR_W-1:0] nibble_ascii(input logic [3:0] n);
    logic [CHAR_W-1:0] w;
    w = {4'h0, n};
    if (n > 4'd9) begin
      return "A" + (w - 8'd10);
    end
    return "0" + w;
  endfunction

  // A buffer counts as full once one more line would not fit with a byte to spare.
  function automatic logic buffer_full(input logic [BUF_W-1:0] b);
    int lvl;
    lvl = fill[b];
    return (lvl >= TB_BUF_BYTES) || (TB_BUF_BYTES - lvl <= LINE_CHARS);
  endfunction

  function automatic logic [READY_W-1:0] ready_mask();
    logic [READY_W-1:0] m;
    m = '0;
    for (int i = 0; i < TB_NUM_BUFS; i++) begin
      m[i] = rdy_bit[i];
    end
    return m;
  endfunction

  function automatic void push_single(input logic [BUF_W-1:0] b, input status_e st,
                                      input logic [RLEN_W-1:0] rlen);
    buf_write_t w;
    w = '{ch: CH_NUL, bnum: b, pos: '0, st: st, rlen: rlen, rdy: ready_mask(), last: 1'b1};
    expected_writes.push_back(w);
  endfunction

  function automatic void predict_writes(input log_op_e op, input logic [ID_W-1:0] id,
                                         input logic [LEN_W-1:0] len,
                                         input logic [DATA_W-1:0] data,
                                         input logic [STAMP_W-1:0] stamp,
                                         input logic [SEL_W-1:0] sel);
    logic [CHAR_W-1:0] txt [LINE_CHARS];
    logic [7:0]        dbyte;
    logic [BUF_W-1:0]  wbuf;
    logic [RLEN_W-1:0] base;
    logic [RLEN_W-1:0] old_fill;
    buf_write_t        w;
    int                dlen;
    if (op == OP_RELEASE) begin
      if (sel >= TB_NUM_BUFS) begin
        push_single(sel, ST_BAD_BUF, '0);
      end else begin
        old_fill = fill[sel];
        fill[sel] = '0;
        rdy_bit[sel] = 1'b0;
        push_single(sel, ST_RELEASED, old_fill);
      end
      return;
    end
    for (int i = 0; i < TB_NUM_BUFS; i++) begin
      if (!buffer_full(cur_buf)) break;
      rdy_bit[cur_buf] = 1'b1;
      cur_buf = (cur_buf == TB_NUM_BUFS - 1) ? '0 : cur_buf + 1'b1;
    end
    if (buffer_full(cur_buf)) begin
      push_single(cur_buf, ST_DROP, '0);
      return;
    end
    for (int k = 0; k < 8; k++) begin
      txt[k]      = nibble_ascii(line_no[28 - 4 * k +: 4]);
      txt[40 + k] = nibble_ascii(stamp[28 - 4 * k +: 4]);
    end
    txt[8]  = CH_SPACE;
    txt[9]  = nibble_ascii(id[11:8]);
    txt[10] = nibble_ascii(id[7:4]);
    txt[11] = nibble_ascii(id[3:0]);
    txt[12] = CH_SPACE;
    txt[13] = nibble_ascii(len);
    txt[14] = CH_COLON;
    txt[15] = CH_SPACE;
    // Data is right-aligned: the leading slots stay blank for short frames.
    dlen = (len > 4'd8) ? 8 : int'(len);
    for (int i = 0; i < 8; i++) begin
      if (dlen + i >= 8) begin
        dbyte = data[8 * (dlen + i - 8) +: 8];
        txt[16 + 3 * i] = nibble_ascii(dbyte[7:4]);
        txt[17 + 3 * i] = nibble_ascii(dbyte[3:0]);
      end else begin
        txt[16 + 3 * i] = CH_SPACE;
        txt[17 + 3 * i] = CH_SPACE;
      end
      txt[18 + 3 * i] = CH_SPACE;
    end
    txt[48] = CH_NEWLINE;
    line_no = line_no + 1;
    wbuf = cur_buf;
    base = fill[wbuf];
    fill[wbuf] = RLEN_W'(base + LINE_CHARS);
    if (buffer_full(wbuf)) begin
      rdy_bit[wbuf] = 1'b1;
      cur_buf = (cur_buf == TB_NUM_BUFS - 1) ? '0 : cur_buf + 1'b1;
    end
    for (int k = 0; k < LINE_CHARS; k++) begin
      w = '{ch: txt[k], bnum: wbuf, pos: POS_W'(base + k), st: ST_CHAR, rlen: '0,
            rdy: ready_mask(), last: (k == LINE_CHARS - 1)};
      expected_writes.push_back(w);
    end
  endfunction

  function automatic void report(input string what);
    errors++;
    if (errors <= 10) begin
      $display("%0t ns: %s", $realtime, what);
      $display("  got:  char %h buf %0d pos %0d status %0d rlen %0d ready %b last %b",
               got_write.ch, got_write.bnum, got_write.pos, got_write.st, got_write.rlen,
               got_write.rdy, got_write.last);
      if (what != "result with nothing expected") begin
        $display("  want: char %h buf %0d pos %0d status %0d rlen %0d ready %b last %b",
                 want_write.ch, want_write.bnum, want_write.pos, want_write.st,
                 want_write.rlen, want_write.rdy, want_write.last);
      end
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_no <= '0;
      cur_buf <= '0;
      for (int i = 0; i < TB_NUM_BUFS; i++) begin
        fill[i]    <= '0;
        rdy_bit[i] <= 1'b0;
      end
      expected_writes.delete();
      errors       = 0;
      checked      = 0;
      drops        = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
      checked_o    <= 0;
      drops_o      <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        got_write = '{ch: out_data_i[7:0], bnum: out_data_i[10:8], pos: out_data_i[19:11],
                      st: status_e'(out_user_i), rlen: out_data_i[29:20],
                      rdy: out_data_i[34:30], last: out_last_i};
        checked++;
        if (got_write.st == ST_DROP) begin
          drops++;
        end
        if (expected_writes.size() == 0) begin
          report("result with nothing expected");
        end else begin
          want_write = expected_writes.pop_front();
          if (got_write !== want_write) begin
            report("result mismatch");
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        predict_writes(log_op_e'(in_user_i[0]), in_data_i[11:0], in_data_i[15:12],
                       in_data_i[79:16], in_data_i[111:80], in_data_i[114:112]);
      end
      fail_count_o <= errors;
      pending_o    <= expected_writes.size();
      checked_o    <= checked;
      drops_o      <= drops;
    end
  end

endmodule

@@ test/tb_can_frame_text_logger.sv @@
// Testbench top for the CAN frame text logger: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_can_frame_text_logger;
  import cftl_pkg::*;
  import tb_cftl_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int DRAIN_CYCLES = 24;
  localparam int ITEM_TARGET = 210;

  logic         clk_i;
  logic         rst_ni;
  logic         s_tvalid;
  logic         s_tready;
  logic [119:0] s_tdata;
  logic [0:0]   s_tuser;
  logic         m_tvalid;
  logic         m_tready;
  logic [39:0]  m_tdata;
  logic [1:0]   m_tuser;
  logic         m_tlast;

  int fails;
  int pending;
  int checked;
  int drops;
  int cycles;
  int frames_sent;
  int releases_sent;
  int send_calm;
  int recv_calm;

  can_frame_text_logger #(
    .NUM_BUFFERS (TB_NUM_BUFS),
    .BUFFER_BYTES(TB_BUF_BYTES)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tuser_i (s_tuser),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata),
    .m_axis_tuser_o (m_tuser),
    .m_axis_tlast_o (m_tlast)
  );

  cftl_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_tvalid),
    .in_ready_i  (s_tready),
    .in_data_i   (s_tdata),
    .in_user_i   (s_tuser),
    .out_valid_i (m_tvalid),
    .out_ready_i (m_tready),
    .out_data_i  (m_tdata),
    .out_user_i  (m_tuser),
    .out_last_i  (m_tlast),
    .fail_count_o(fails),
    .pending_o   (pending),
    .checked_o   (checked),
    .drops_o     (drops)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Draws an idle gap, with occasional stretches where no idling happens at all.
  function automatic int idle_gap(ref int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 7) == 0) begin
      calm = $urandom_range(5, 30);
    end
    return $urandom_range(0, 9);
  endfunction

  task automatic send_item(input log_op_e op, input logic [11:0] id, input logic [3:0] len,
                           input logic [63:0] data, input logic [31:0] stamp,
                           input logic [2:0] sel);
    int gap;
    gap = idle_gap(send_calm);
    repeat (gap) begin
      @(negedge clk_i);
      s_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_tvalid <= 1'b1;
    s_tdata  <= {5'b0, sel, stamp, data, len, id};
    s_tuser  <= op;
    do @(posedge clk_i); while (!(s_tvalid && s_tready));
    if (op == OP_LOG) begin
      frames_sent++;
    end else begin
      releases_sent++;
    end
  endtask

  task automatic log_random();
    logic [3:0] len;
    len = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(0, 8));
    send_item(OP_LOG, 12'($urandom), len, {$urandom, $urandom}, $urandom,
              3'($urandom_range(0, 7)));
  endtask

  task automatic release_buf(input logic [2:0] sel);
    send_item(OP_RELEASE, 12'($urandom), 4'($urandom), {$urandom, $urandom}, $urandom, sel);
  endtask

  // Result side: a random idle gap, possibly none, before every transfer.
  initial begin
    int gap;
    m_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      gap = idle_gap(recv_calm);
      repeat (gap) begin
        @(negedge clk_i);
        m_tready <= 1'b0;
      end
      @(negedge clk_i);
      m_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_tvalid && m_tready));
    end
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Timeout after %0d cycles with %0d results outstanding", cycles, pending);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int burst;
    int first;
    int room;
    s_tvalid      = 1'b0;
    s_tdata       = '0;
    s_tuser       = OP_LOG;
    rst_ni        = 1'b0;
    frames_sent   = 0;
    releases_sent = 0;
    send_calm     = 0;
    recv_calm     = 0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part: field extremes, short and overlong lengths, releases and bad buffers.
    send_item(OP_LOG, 12'h000, 4'd0, 64'h0, 32'h0, 3'd0);
    send_item(OP_LOG, 12'hFFF, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 3'd7);
    send_item(OP_LOG, 12'h123, 4'd1, 64'h0123_4567_89AB_CDEF, 32'h89AB_CDEF, 3'd5);
    send_item(OP_LOG, 12'h7FF, 4'd4, 64'hFEDC_BA98_7654_3210, 32'h1234_5678, 3'd2);
    send_item(OP_LOG, 12'h800, 4'd7, 64'hA5A5_5A5A_C3C3_3C3C, 32'h8000_0000, 3'd1);
    send_item(OP_LOG, 12'hABC, 4'd9, 64'h1122_3344_5566_7788, 32'h0000_0001, 3'd3);
    send_item(OP_LOG, 12'h5A5, 4'd15, 64'h99AA_BBCC_DDEE_FF00, 32'h7FFF_FFFF, 3'd6);
    release_buf(3'd0);
    release_buf(3'd3);
    release_buf(3'd5);
    release_buf(3'd6);
    release_buf(3'd7);
    send_item(OP_LOG, 12'h0F0, 4'd2, 64'h0000_0000_0000_BEEF, 32'hDEAD_BEEF, 3'd4);
    send_item(OP_LOG, 12'hF0F, 4'd3, 64'h0000_0000_00CA_FE01, 32'h0F0F_0F0F, 3'd0);
    send_item(OP_LOG, 12'h3C3, 4'd5, 64'h0000_00FF_EE00_11DD, 32'hF0F0_F0F0, 3'd7);
    send_item(OP_LOG, 12'hC3C, 4'd6, 64'h0000_8001_7FFE_0180, 32'h5555_AAAA, 3'd2);
    release_buf(3'd4);

    // Random part: long runs of frames that can fill the ring and reach drops,
    // each followed by freeing every buffer.
    while (frames_sent + releases_sent < ITEM_TARGET) begin
      room  = ITEM_TARGET - frames_sent - releases_sent - (TB_NUM_BUFS + 1);
      burst = $urandom_range(40, 70);
      if (burst > room) begin
        burst = (room > 0) ? room : 0;
      end
      repeat (burst) begin
        if ($urandom_range(0, 15) == 0) begin
          release_buf(3'($urandom_range(0, 7)));
        end else begin
          log_random();
        end
      end
      first = $urandom_range(0, TB_NUM_BUFS - 1);
      for (int i = 0; i < TB_NUM_BUFS; i++) begin
        release_buf(3'((first + i) % TB_NUM_BUFS));
      end
      release_buf(3'($urandom_range(TB_NUM_BUFS, 7)));
    end

    @(negedge clk_i);
    s_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d frames and %0d release requests over %0d cycles.",
             frames_sent, releases_sent, cycles);
    $display("Checked %0d buffer writes and status results, %0d of them dropped frames.",
             checked, drops);
    if (fails == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches, %0d results outstanding", fails, pending);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
